### rtl/qgf_pkg.sv
// Shared types and constants for the quad gate fit mean error unit.
// No dependencies; every other file but qgf_ram refers to it by scoped names.
package qgf_pkg;

    localparam int DIST_W = 15;              // Q11.4 distance width
    localparam int K_W    = $clog2(DIST_W);  // root search bit index
    localparam int DW     = 21;              // signed coordinate difference width
    localparam int PW     = 2 * DW;          // products and their sums
    localparam int CW     = 4 * DW;          // squared cross product and root trials

    localparam logic [DIST_W-1:0] CLAMP_RESET = 15'd320;  // 20.0 px

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [10:0]        point_x;
        logic [10:0]        point_y;
        logic signed [15:0] gate_x;
        logic signed [15:0] gate_y;
        logic signed [15:0] half_width;
        logic signed [15:0] half_left;
        logic signed [15:0] half_right;
    } t_cmd;

    typedef struct packed {
        logic [14:0] mean_error;
        logic [10:0] stored_points;
        logic        dropped;
    } t_result;

    typedef struct packed {
        logic signed [DW-1:0] ax;
        logic signed [DW-1:0] ay;
        logic signed [DW-1:0] bx;
        logic signed [DW-1:0] by;
    } t_seg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIST,
        ST_DIV
    } t_state;

endpackage

### rtl/qgf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module qgf_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/qgf_side_dist.sv
// Point-to-segment distance for one quadrilateral side, floor in Q11.4.
// Five product/sum stages, then a 15-step shift-add root search. Uses qgf_pkg.
module qgf_side_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  qgf_pkg::t_seg               i_seg,
    input  logic signed [qgf_pkg::DW-1:0] i_px,
    input  logic signed [qgf_pkg::DW-1:0] i_py,
    output logic                        o_done,
    output logic [qgf_pkg::DIST_W-1:0]  o_dist
);

    localparam int DW = qgf_pkg::DW;
    localparam int PW = qgf_pkg::PW;
    localparam int CW = qgf_pkg::CW;
    localparam int QW = qgf_pkg::DIST_W;

    logic [4:0] r_v;
    logic       r_run;
    logic       r_done;
    logic [qgf_pkg::K_W-1:0] r_k;

    // stage 1: differences
    logic signed [DW-1:0] r_dx, r_dy, r_vx, r_vy, r_wx, r_wy;
    // stage 2: products
    logic signed [PW-1:0] r_dxx, r_dyy, r_vxdx, r_vydy, r_dxvy, r_dyvx;
    logic signed [PW-1:0] r_vxx, r_vyy, r_wxx, r_wyy;
    // stage 3: sums
    logic signed [PW-1:0] r_len2, r_t, r_cross, r_sqa, r_sqb;
    // stage 4: case select
    logic          r_ep4;
    logic [PW-1:0] r_sq4, r_l4;
    logic [DW-1:0] r_hi, r_lo;
    // stage 5: partial products of the squared cross product
    logic          r_ep5;
    logic [PW-1:0] r_sq5, r_l5, r_hh, r_hl, r_ll;
    // root search: A = q^2*L, Q = q*L << (k+1), P = L << 2k
    logic [CW-1:0] r_a, r_q, r_p, r_c;
    logic [QW-1:0] r_qv;

    logic signed [PW-1:0] mag_s;
    logic [CW-1:0]        trial;
    logic                 fit;

    always_comb begin
        mag_s = (r_cross < 0) ? -r_cross : r_cross;
        trial = r_a + r_q + r_p;
        fit   = (trial <= r_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_v    <= {r_v[3:0], i_start};
            r_done <= 1'b0;
            if (r_v[4]) begin
                r_run <= 1'b1;
                r_k   <= qgf_pkg::K_W'(QW - 1);
            end else if (r_run) begin
                r_k <= r_k - 1'b1;
                if (r_k == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= i_seg.bx - i_seg.ax;
        r_dy <= i_seg.by - i_seg.ay;
        r_vx <= i_px - i_seg.ax;
        r_vy <= i_py - i_seg.ay;
        r_wx <= i_px - i_seg.bx;
        r_wy <= i_py - i_seg.by;

        r_dxx  <= r_dx * r_dx;
        r_dyy  <= r_dy * r_dy;
        r_vxdx <= r_vx * r_dx;
        r_vydy <= r_vy * r_dy;
        r_dxvy <= r_dx * r_vy;
        r_dyvx <= r_dy * r_vx;
        r_vxx  <= r_vx * r_vx;
        r_vyy  <= r_vy * r_vy;
        r_wxx  <= r_wx * r_wx;
        r_wyy  <= r_wy * r_wy;

        r_len2  <= r_dxx + r_dyy;
        r_t     <= r_vxdx + r_vydy;
        r_cross <= r_dxvy - r_dyvx;
        r_sqa   <= r_vxx + r_vyy;
        r_sqb   <= r_wxx + r_wyy;

        // foot before A or degenerate side: endpoint A; beyond B: endpoint B
        if (r_len2 == '0 || r_t <= 0) begin
            r_ep4 <= 1'b1;
            r_sq4 <= $unsigned(r_sqa);
        end else if (r_t >= r_len2) begin
            r_ep4 <= 1'b1;
            r_sq4 <= $unsigned(r_sqb);
        end else begin
            r_ep4 <= 1'b0;
            r_sq4 <= $unsigned(r_sqa);
        end
        r_l4 <= $unsigned(r_len2);
        r_hi <= mag_s[PW-1:DW];
        r_lo <= mag_s[DW-1:0];

        r_ep5 <= r_ep4;
        r_sq5 <= r_sq4;
        r_l5  <= r_l4;
        r_hh  <= r_hi * r_hi;
        r_hl  <= r_hi * r_lo;
        r_ll  <= r_lo * r_lo;

        if (r_v[4]) begin
            r_a  <= '0;
            r_q  <= '0;
            r_qv <= '0;
            if (r_ep5) begin
                r_c <= CW'(r_sq5);
                r_p <= CW'(1) << (2 * (QW - 1));
            end else begin
                r_c <= (CW'(r_hh) << (2 * DW)) + (CW'(r_hl) << (DW + 1)) + CW'(r_ll);
                r_p <= CW'(r_l5) << (2 * (QW - 1));
            end
        end else if (r_run) begin
            if (fit) begin
                r_a       <= trial;
                r_q       <= (r_q + (r_p << 1)) >> 1;
                r_qv[r_k] <= 1'b1;
            end else begin
                r_q <= r_q >> 1;
            end
            r_p <= r_p >> 2;
        end
    end

    assign o_done = r_done;
    assign o_dist = r_qv;

endmodule

### rtl/qgf_div.sv
// Restoring divider for the mean: sum / count, 15-bit quotient, one bit a cycle.
// Uses qgf_pkg.
module qgf_div #(
    parameter int CNT_W = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [qgf_pkg::DIST_W+CNT_W-1:0]    i_sum,
    input  logic [CNT_W-1:0]                    i_den,
    output logic                                o_done,
    output logic [qgf_pkg::DIST_W-1:0]          o_quot
);

    localparam int SUM_W = qgf_pkg::DIST_W + CNT_W;
    localparam int QW    = qgf_pkg::DIST_W;

    logic                    r_run;
    logic                    r_done;
    logic [qgf_pkg::K_W-1:0] r_k;
    logic [SUM_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_den;
    logic [QW-1:0]           r_quot;
    logic [SUM_W-1:0]        dsh;

    // quotient is known to stay below 2^15, so top-down trial shifts suffice
    assign dsh = SUM_W'(r_den) << r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_k   <= qgf_pkg::K_W'(QW - 1);
            end else if (r_run) begin
                r_k <= r_k - 1'b1;
                if (r_k == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_sum;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_run && r_rem >= dsh) begin
            r_rem       <= r_rem - dsh;
            r_quot[r_k] <= 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/quad_gate_fit_mean_error_unit.sv
// Quad gate fit mean error unit: point store plus mean clamped distance to a quad.
// Depends on qgf_pkg, qgf_ram, qgf_side_dist and qgf_div.
//
// Usage: drive i_cmd and raise start while busy is low; that edge takes the
// transaction. Exactly one result follows on o_result, marked by o_done for
// one cycle; the receiver has no way to stall it, so capture it then.
// Clear, append and unused codes answer one cycle after acceptance and busy
// never rises for them, so such commands may be issued every cycle.
// Evaluate walks the stored points one at a time: each point passes through the
// RAM read, five product/sum stages, root setup, the 15-step root search that
// all four side units run in parallel, and the accumulate; then the 15-step
// divider forms the mean. With an empty store it answers in the cycle after
// acceptance, like a clear. busy stays high until the result.
// The clamp register is written through i_cfg_valid/i_cfg_data, always ready;
// write it only while the unit is idle. Reset (synchronous, active low)
// empties the store, sets the clamp to 20.0 px and needs no clearing pass:
// only entries below the point count are ever read.
module quad_gate_fit_mean_error_unit #(
    parameter int MAX_STORED = 1024,
    parameter int COORD_BITS = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  qgf_pkg::t_cmd               i_cmd,
    output logic                        o_done,
    output qgf_pkg::t_result            o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [qgf_pkg::DIST_W-1:0]  i_cfg_data
);

    localparam int AW    = $clog2(MAX_STORED);
    localparam int CNT_W = $clog2(MAX_STORED + 1);
    localparam int PT_W  = 2 * COORD_BITS;
    localparam int SUM_W = qgf_pkg::DIST_W + CNT_W;
    localparam int DW    = qgf_pkg::DW;
    localparam int QW    = qgf_pkg::DIST_W;

    qgf_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]    r_idx, n_idx;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             r_done, n_done;
    qgf_pkg::t_result r_res, n_res;
    logic [QW-1:0]    r_clamp;

    logic signed [DW-1:0] r_lx, r_rx, r_tly, r_bly, r_try, r_bry;
    logic signed [DW-1:0] gx, gy, hw, hl, hr;
    logic signed [DW-1:0] px, py;

    logic                ram_we, ram_re;
    logic [PT_W-1:0]     ram_wdata, ram_rdata;
    logic                side_start;
    qgf_pkg::t_seg       seg [4];
    logic [3:0]          side_done;
    logic [QW-1:0]       side_dist [4];
    logic [QW-1:0]       best;
    logic                div_start, div_done;
    logic [QW-1:0]       div_quot;
    logic                last_pt;

    assign gx = DW'(i_cmd.gate_x);
    assign gy = DW'(i_cmd.gate_y);
    assign hw = DW'(i_cmd.half_width);
    assign hl = DW'(i_cmd.half_left);
    assign hr = DW'(i_cmd.half_right);

    assign px = DW'({ram_rdata[COORD_BITS-1:0], 4'b0000});
    assign py = DW'({ram_rdata[PT_W-1:COORD_BITS], 4'b0000});

    assign ram_wdata = {COORD_BITS'(i_cmd.point_y), COORD_BITS'(i_cmd.point_x)};

    // left, right, top, bottom
    assign seg[0] = '{ax: r_lx, ay: r_bly, bx: r_lx, by: r_tly};
    assign seg[1] = '{ax: r_rx, ay: r_bry, bx: r_rx, by: r_try};
    assign seg[2] = '{ax: r_lx, ay: r_tly, bx: r_rx, by: r_try};
    assign seg[3] = '{ax: r_lx, ay: r_bly, bx: r_rx, by: r_bry};

    qgf_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_STORED)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    for (genvar s = 0; s < 4; s++) begin : g_side
        qgf_side_dist u_side (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (side_start),
            .i_seg   (seg[s]),
            .i_px    (px),
            .i_py    (py),
            .o_done  (side_done[s]),
            .o_dist  (side_dist[s])
        );
    end

    qgf_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (n_sum),
        .i_den   (r_count),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        best = r_clamp;
        for (int s = 0; s < 4; s++) begin
            if (side_dist[s] < best) begin
                best = side_dist[s];
            end
        end
    end

    assign last_pt = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_sum      = r_sum;
        n_done     = 1'b0;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        side_start = 1'b0;
        div_start  = 1'b0;
        unique case (r_state)
            qgf_pkg::ST_IDLE: begin
                if (start) begin
                    n_done             = 1'b1;
                    n_res.mean_error   = '0;
                    n_res.dropped      = 1'b0;
                    n_res.stored_points = 11'(r_count);
                    unique case (i_cmd.op)
                        qgf_pkg::OP_CLEAR: begin
                            n_count             = '0;
                            n_res.stored_points = '0;
                        end
                        qgf_pkg::OP_APPEND: begin
                            if (r_count == CNT_W'(MAX_STORED)) begin
                                n_res.dropped = 1'b1;
                            end else begin
                                ram_we              = 1'b1;
                                n_count             = r_count + 1'b1;
                                n_res.stored_points = 11'(n_count);
                            end
                        end
                        qgf_pkg::OP_EVAL: begin
                            if (r_count != '0) begin
                                n_done  = 1'b0;
                                n_idx   = '0;
                                n_sum   = '0;
                                n_state = qgf_pkg::ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            qgf_pkg::ST_READ: begin
                ram_re  = 1'b1;
                n_state = qgf_pkg::ST_LOAD;
            end
            qgf_pkg::ST_LOAD: begin
                side_start = 1'b1;
                n_state    = qgf_pkg::ST_DIST;
            end
            qgf_pkg::ST_DIST: begin
                if (side_done[0]) begin
                    n_sum = r_sum + SUM_W'(best);
                    if (last_pt) begin
                        div_start = 1'b1;
                        n_state   = qgf_pkg::ST_DIV;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = qgf_pkg::ST_READ;
                    end
                end
            end
            qgf_pkg::ST_DIV: begin
                if (div_done) begin
                    n_done              = 1'b1;
                    n_res.mean_error    = div_quot;
                    n_res.stored_points = 11'(r_count);
                    n_res.dropped       = 1'b0;
                    n_state             = qgf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = qgf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qgf_pkg::ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_clamp <= qgf_pkg::CLAMP_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                r_clamp <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_sum <= n_sum;
        r_res <= n_res;
        if (start && !busy && i_cmd.op == qgf_pkg::OP_EVAL) begin
            r_lx  <= gx - hw;
            r_rx  <= gx + hw;
            r_tly <= gy + hl;
            r_bly <= gy - hl;
            r_try <= gy + hr;
            r_bry <= gy - hr;
        end
    end

    assign busy        = (r_state != qgf_pkg::ST_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_STORED))
        else $error("point count above store depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.op == qgf_pkg::OP_EVAL && r_count != '0) |=> busy)
        else $error("evaluation did not start");

    a_side_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        side_done[0] == side_done[1] && side_done[0] == side_done[2]
        && side_done[0] == side_done[3])
        else $error("side units out of step");

endmodule

### tb/sv/tb.sv
// Testbench for quad_gate_fit_mean_error_unit: predicts clear/append/evaluate results
// and compares every strobed result. Depends on qgf_pkg and the unit's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    class gate_fit_scoreboard;
        logic [10:0] px_store[1024];
        logic [10:0] py_store[1024];
        int unsigned held;
        int unsigned clamp;
        qgf_pkg::t_result pending[$];
        int          errors;
        int          evals;
        int          drops;

        function new();
            held = 0;
            clamp = qgf_pkg::CLAMP_RESET;
            errors = 0;
            evals = 0;
            drops = 0;
        endfunction

        // largest q <= lim with q*q*den <= num
        function int unsigned root_ratio(bit [127:0] num, bit [127:0] den, int unsigned lim);
            int unsigned lo, hi, mid;
            bit [127:0] prod;
            lo = 0;
            hi = lim;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                prod = 128'(mid) * 128'(mid) * den;
                if (prod <= num) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        function int unsigned end_dist(longint ax, longint ay, longint qx, longint qy,
                                       int unsigned lim);
            longint vx, vy;
            vx = qx - ax;
            vy = qy - ay;
            return root_ratio(128'(vx * vx + vy * vy), 128'd1, lim);
        endfunction

        function int unsigned side_dist(longint ax, longint ay, longint bx, longint by,
                                        longint qx, longint qy, int unsigned lim);
            longint dx, dy, vx, vy, len2, t, xprod;
            bit [127:0] mag;
            dx = bx - ax;
            dy = by - ay;
            vx = qx - ax;
            vy = qy - ay;
            len2 = dx * dx + dy * dy;
            t = vx * dx + vy * dy;
            if (len2 == 0 || t <= 0) return end_dist(ax, ay, qx, qy, lim);
            if (t >= len2) return end_dist(bx, by, qx, qy, lim);
            xprod = dx * vy - dy * vx;
            mag = 128'(xprod < 0 ? -xprod : xprod);
            return root_ratio(mag * mag, 128'(len2), lim);
        endfunction

        function void note(qgf_pkg::t_cmd c);
            qgf_pkg::t_result r;
            longint lx, rx, tly, bly, try_, bry, qx, qy;
            longint unsigned sum;
            int unsigned best, d;
            r = '0;
            case (c.op)
                qgf_pkg::OP_CLEAR: held = 0;
                qgf_pkg::OP_APPEND: begin
                    if (held >= 1024) begin
                        r.dropped = 1'b1;
                        drops++;
                    end else begin
                        px_store[held] = c.point_x;
                        py_store[held] = c.point_y;
                        held++;
                    end
                end
                qgf_pkg::OP_EVAL: begin
                    evals++;
                    if (held > 0) begin
                        lx = longint'(c.gate_x) - longint'(c.half_width);
                        rx = longint'(c.gate_x) + longint'(c.half_width);
                        tly = longint'(c.gate_y) + longint'(c.half_left);
                        bly = longint'(c.gate_y) - longint'(c.half_left);
                        try_ = longint'(c.gate_y) + longint'(c.half_right);
                        bry = longint'(c.gate_y) - longint'(c.half_right);
                        sum = 0;
                        for (int i = 0; i < held; i++) begin
                            qx = longint'(px_store[i]) * 16;
                            qy = longint'(py_store[i]) * 16;
                            best = clamp;
                            d = side_dist(lx, bly, lx, tly, qx, qy, best);
                            if (d < best) best = d;
                            d = side_dist(rx, bry, rx, try_, qx, qy, best);
                            if (d < best) best = d;
                            d = side_dist(lx, tly, rx, try_, qx, qy, best);
                            if (d < best) best = d;
                            d = side_dist(lx, bly, rx, bry, qx, qy, best);
                            if (d < best) best = d;
                            sum += best;
                        end
                        r.mean_error = 15'(sum / held);
                    end
                end
                default: ;
            endcase
            r.stored_points = 11'(held);
            pending.push_back(r);
        endfunction

        function void check(qgf_pkg::t_result got);
            qgf_pkg::t_result want;
            if (pending.size() == 0) begin
                $error("result with no transaction outstanding: %p", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.mean_error !== want.mean_error) begin
                $error("mean_error expected %0d got %0d", want.mean_error, got.mean_error);
                errors++;
            end
            if (got.stored_points !== want.stored_points) begin
                $error("stored_points expected %0d got %0d",
                       want.stored_points, got.stored_points);
                errors++;
            end
            if (got.dropped !== want.dropped) begin
                $error("dropped expected %0d got %0d", want.dropped, got.dropped);
                errors++;
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    qgf_pkg::t_cmd     cmd;
    logic     o_done;
    qgf_pkg::t_result  o_result;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    logic [qgf_pkg::DIST_W-1:0] i_cfg_data;

    gate_fit_scoreboard sb;
    int items_sent;
    int stall_cycles;
    int max_gap;
    int base_x, base_y;

    quad_gate_fit_mean_error_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check(o_result);
    end

    // watchdog: allow plenty beyond the length of a full-store evaluation
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 200000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(qgf_pkg::t_cmd c);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        cmd <= c;
        do @(posedge i_clk); while (busy);
        sb.note(c);
        items_sent++;
    endtask

    // hold off until every expected result is in and the unit is idle
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0 || busy);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_clamp(int unsigned v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= qgf_pkg::DIST_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.clamp = v;
    endtask

    function automatic qgf_pkg::t_cmd mk(logic [1:0] op, int x, int y, int gx, int gy,
                                         int hw, int hl, int hr);
        qgf_pkg::t_cmd c;
        c.op = op;
        c.point_x = 11'(x);
        c.point_y = 11'(y);
        c.gate_x = 16'(gx);
        c.gate_y = 16'(gy);
        c.half_width = 16'(hw);
        c.half_left = 16'(hl);
        c.half_right = 16'(hr);
        return c;
    endfunction

    function automatic qgf_pkg::t_cmd rand_cmd(logic [1:0] op);
        qgf_pkg::t_cmd c;
        c = qgf_pkg::t_cmd'({$urandom, $urandom, $urandom});
        c.op = op;
        return c;
    endfunction

    // points mostly clustered around the phase base so most distances land below the clamp
    function automatic qgf_pkg::t_cmd near_point();
        qgf_pkg::t_cmd c;
        c = rand_cmd(qgf_pkg::OP_APPEND);
        if ($urandom_range(0, 9) != 0) begin
            c.point_x = 11'(base_x + $urandom_range(0, 60));
            c.point_y = 11'(base_y + $urandom_range(0, 60));
        end
        return c;
    endfunction

    function automatic qgf_pkg::t_cmd near_gate();
        qgf_pkg::t_cmd c;
        c = rand_cmd(qgf_pkg::OP_EVAL);
        if ($urandom_range(0, 4) != 0) begin
            c.gate_x = 16'((base_x + 30) * 16 + $urandom_range(0, 400) - 200);
            c.gate_y = 16'((base_y + 30) * 16 + $urandom_range(0, 400) - 200);
            c.half_width = 16'($urandom_range(0, 700) - 100);
            c.half_left = 16'($urandom_range(0, 700) - 100);
            c.half_right = 16'($urandom_range(0, 700) - 100);
        end
        return c;
    endfunction

    initial begin
        int n;
        sb = new();
        items_sent = 0;
        max_gap = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extreme points, degenerate and inverted quads
        send(mk(qgf_pkg::OP_EVAL, 0, 0, 100, 100, 16, 16, 16));
        send(mk(qgf_pkg::OP_APPEND, 0, 0, 0, 0, 0, 0, 0));
        send(mk(qgf_pkg::OP_APPEND, 2047, 2047, 0, 0, 0, 0, 0));
        send(mk(qgf_pkg::OP_APPEND, 10, 12, 0, 0, 0, 0, 0));
        send(mk(qgf_pkg::OP_EVAL, 0, 0, 160, 192, 0, 0, 0));
        send(mk(qgf_pkg::OP_EVAL, 0, 0, 160, 192, 80, 0, 0));
        send(mk(qgf_pkg::OP_EVAL, 0, 0, 160, 192, 0, 48, -48));
        send(mk(qgf_pkg::OP_EVAL, 0, 0, 160, 192, -64, -32, 96));
        send(mk(qgf_pkg::OP_EVAL, 0, 0, -32768, 32767, 32767, -32768, 32767));
        send(mk(qgf_pkg::OP_EVAL, 0, 0, 32767, -32768, -32768, 32767, -32768));
        send(mk(3, 2047, 2047, -1, -1, -1, -1, -1));
        drain();
        write_clamp(32767);
        send(mk(qgf_pkg::OP_EVAL, 0, 0, 32767, 32767, 32767, 32767, 32767));
        send(mk(qgf_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0, 0));
        drain();
        write_clamp(0);
        send(mk(qgf_pkg::OP_EVAL, 0, 0, 160, 192, 16, 16, 16));
        send(mk(qgf_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send(mk(qgf_pkg::OP_EVAL, 0, 0, 160, 192, 16, 16, 16));
        drain();
        write_clamp(qgf_pkg::CLAMP_RESET);

        // fill the store to capacity, overflow it, evaluate over every entry
        base_x = 500;
        base_y = 700;
        max_gap = 19;
        send(mk(qgf_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        repeat (1027) send(near_point());
        send(near_gate());
        drain();
        write_clamp(32767);
        send(rand_cmd(qgf_pkg::OP_EVAL));
        send(near_gate());
        send(mk(qgf_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));

        // random phases on small stores
        while (items_sent < 1250) begin
            drain();
            case ($urandom_range(0, 5))
                0: write_clamp(0);
                1: write_clamp(32767);
                2: write_clamp($urandom_range(0, 32767));
                default: write_clamp($urandom_range(16, 800));
            endcase
            max_gap = 19;
            base_x = $urandom_range(0, 1980);
            base_y = $urandom_range(0, 1980);
            send(mk(qgf_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
            n = $urandom_range(1, 12);
            repeat (n) send(near_point());
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0) send(rand_cmd(2'($urandom_range(0, 3))));
                send(near_gate());
            end
        end
        drain();
        repeat (40) @(posedge i_clk);

        $display("Covered %0d transactions: %0d evaluations, %0d dropped appends,",
                 items_sent, sb.evals, sb.drops);
        $display("clamp from 0 to 32767, full store, degenerate and inverted quads.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
